FILE: hw/rtl/pfm_pkg.sv
// pfm_pkg: shared constants for the plane frame matrices unit
// widths of the normalized magnitudes, the squared sum and the square root
// no dependencies
package pfm_pkg;

   // the largest normalized magnitude lies in [2^29, 2^30)
   localparam int NORM_BITS = 30;

   // sum of three squares of normalized magnitudes
   localparam int SQ_W = 2 * NORM_BITS + 2;

   // integer square root of that sum
   localparam int ROOT_W = NORM_BITS + 1;

   // divisor width (twice the root)
   localparam int DEN_W = ROOT_W + 1;

   // number of vector lanes through the divider: three for z, two for x
   localparam int LANES = 5;

endpackage

FILE: hw/rtl/plane_frame_matrices_unit.sv
// plane_frame_matrices_unit: orthonormal frame and inverse translation of a plane
// depends on pfm_pkg, pfm_sqrt_cell, pfm_div_cell
// throughput: one plane per cycle while busy is low; busy is reset delayed by one register
// the pipeline length is set mainly by the square root chain (one cell per root bit) and the
// divider chain (one cell per quotient bit); every cell is busy every cycle
// reset is synchronous and clears only the valid bits; results are never held off
module plane_frame_matrices_unit #(
   parameter int COORD_WIDTH    = 32,
   parameter int AXIS_FRAC_BITS = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [COORD_WIDTH-1:0]      req_origin_x,
   input  logic signed [COORD_WIDTH-1:0]      req_origin_y,
   input  logic signed [COORD_WIDTH-1:0]      req_origin_z,
   input  logic signed [COORD_WIDTH-1:0]      req_normal_x,
   input  logic signed [COORD_WIDTH-1:0]      req_normal_y,
   input  logic signed [COORD_WIDTH-1:0]      req_normal_z,
   output logic                               rsp_strobe,
   output logic signed [AXIS_FRAC_BITS+1:0]   rsp_axis_x_0,
   output logic signed [AXIS_FRAC_BITS+1:0]   rsp_axis_x_1,
   output logic signed [AXIS_FRAC_BITS+1:0]   rsp_axis_x_2,
   output logic signed [AXIS_FRAC_BITS+1:0]   rsp_axis_y_0,
   output logic signed [AXIS_FRAC_BITS+1:0]   rsp_axis_y_1,
   output logic signed [AXIS_FRAC_BITS+1:0]   rsp_axis_y_2,
   output logic signed [AXIS_FRAC_BITS+1:0]   rsp_axis_z_0,
   output logic signed [AXIS_FRAC_BITS+1:0]   rsp_axis_z_1,
   output logic signed [AXIS_FRAC_BITS+1:0]   rsp_axis_z_2,
   output logic signed [COORD_WIDTH-1:0]      rsp_shift_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_shift_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_shift_z
);
   import pfm_pkg::*;

   localparam int W       = COORD_WIDTH;
   localparam int F       = AXIS_FRAC_BITS;
   localparam int AXIS_W  = F + 2;
   localparam int POS_W   = $clog2(W);
   localparam int SH_W    = $clog2(W + 1);
   localparam int WIDE_W  = W + NORM_BITS;
   localparam int DIV_W   = F + NORM_BITS + 2;
   localparam int DIV_N   = F + 1;
   localparam int PW      = 2 * AXIS_W;
   localparam int DW      = AXIS_W + W;
   localparam int TW      = DW + 2;
   localparam int LAT     = ROOT_W + F + 11;
   // sideband layout: {origin z,y,x, lane signs, zero z, zero x}
   localparam int SB_ZX   = 0;
   localparam int SB_ZZ   = 1;
   localparam int SB_S    = 2;
   localparam int SB_O    = SB_S + LANES;
   localparam int SB_W    = SB_O + 3 * W;

   localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(1) << F;
   localparam logic [PW:0]              Y_HALF   = (PW + 1)'(1) << (F - 1);
   localparam logic signed [TW-1:0]     DOT_HALF = TW'(1) <<< (F - 1);
   localparam logic signed [TW-1:0]     SAT_HI   = TW'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [TW-1:0]     SAT_LO   = -SAT_HI - TW'(1);

   logic busy_ff;
   logic accept;

   // ---------------- front stages ----------------
   logic                      p0_v_ff, p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff;
   logic signed [W-1:0]       p0_o_ff [3];
   logic [W-1:0]              p0_mag_ff [3];
   logic [2:0]                p0_neg_ff;
   logic [W-1:0]              or_z, or_x;
   logic [POS_W-1:0]          pos_z, pos_x;
   logic [W-1:0]              p1_mag_ff [3];
   logic [SH_W-1:0]           p1_shz_ff, p1_shx_ff;
   logic [SB_W-1:0]           p1_sb_ff, p1_sb_in;
   logic [NORM_BITS-1:0]      p2_m_ff [LANES];
   logic [SB_W-1:0]           p2_sb_ff, p3_sb_ff, p4_sb_ff;
   logic [NORM_BITS-1:0]      p3_m_ff [LANES];
   logic [NORM_BITS-1:0]      p4_m_ff [LANES];
   logic [2*NORM_BITS-1:0]    p3_sq_ff [LANES];
   logic [SQ_W-1:0]           p4_sz_ff, p4_sx_ff;
   logic [WIDE_W-1:0]         wide [LANES];

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // capture and split into sign and magnitude
   always_ff @(posedge clock) begin
      p0_o_ff[0]   <= req_origin_x;
      p0_o_ff[1]   <= req_origin_y;
      p0_o_ff[2]   <= req_origin_z;
      p0_neg_ff    <= {req_normal_z[W-1], req_normal_y[W-1], req_normal_x[W-1]};
      p0_mag_ff[0] <= req_normal_x[W-1] ? (~req_normal_x + W'(1)) : req_normal_x;
      p0_mag_ff[1] <= req_normal_y[W-1] ? (~req_normal_y + W'(1)) : req_normal_y;
      p0_mag_ff[2] <= req_normal_z[W-1] ? (~req_normal_z + W'(1)) : req_normal_z;
   end

   // leading one of the largest magnitude of each vector
   always_comb begin
      or_z  = p0_mag_ff[0] | p0_mag_ff[1] | p0_mag_ff[2];
      or_x  = p0_mag_ff[0] | p0_mag_ff[1];
      pos_z = '0;
      pos_x = '0;
      for (int i = 0; i < W; i++) begin
         if (or_z[i]) pos_z = POS_W'(i);
         if (or_x[i]) pos_x = POS_W'(i);
      end
      p1_sb_in = '0;
      p1_sb_in[SB_ZX]     = (or_x == '0);
      p1_sb_in[SB_ZZ]     = (or_z == '0);
      p1_sb_in[SB_S + 0]  = p0_neg_ff[0];
      p1_sb_in[SB_S + 1]  = p0_neg_ff[1];
      p1_sb_in[SB_S + 2]  = p0_neg_ff[2];
      p1_sb_in[SB_S + 3]  = !p0_neg_ff[1];
      p1_sb_in[SB_S + 4]  = p0_neg_ff[0];
      p1_sb_in[SB_O +: W]         = p0_o_ff[0];
      p1_sb_in[SB_O + W +: W]     = p0_o_ff[1];
      p1_sb_in[SB_O + 2 * W +: W] = p0_o_ff[2];
   end

   always_ff @(posedge clock) begin
      p1_mag_ff <= p0_mag_ff;
      p1_shz_ff <= SH_W'(pos_z) + SH_W'(1);
      p1_shx_ff <= SH_W'(pos_x) + SH_W'(1);
      p1_sb_ff  <= p1_sb_in;
   end

   // shift so the largest magnitude lands in [2^29, 2^30)
   always_comb begin
      wide[0] = {p1_mag_ff[0], {NORM_BITS{1'b0}}} >> p1_shz_ff;
      wide[1] = {p1_mag_ff[1], {NORM_BITS{1'b0}}} >> p1_shz_ff;
      wide[2] = {p1_mag_ff[2], {NORM_BITS{1'b0}}} >> p1_shz_ff;
      wide[3] = {p1_mag_ff[1], {NORM_BITS{1'b0}}} >> p1_shx_ff;
      wide[4] = {p1_mag_ff[0], {NORM_BITS{1'b0}}} >> p1_shx_ff;
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         p2_m_ff[l] <= wide[l][NORM_BITS-1:0];
      end
      p2_sb_ff <= p1_sb_ff;
   end

   // squares, then the two sums
   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         p3_sq_ff[l] <= (2 * NORM_BITS)'(p2_m_ff[l]) * (2 * NORM_BITS)'(p2_m_ff[l]);
      end
      p3_m_ff  <= p2_m_ff;
      p3_sb_ff <= p2_sb_ff;
      p4_sz_ff <= SQ_W'(p3_sq_ff[0]) + SQ_W'(p3_sq_ff[1]) + SQ_W'(p3_sq_ff[2]);
      p4_sx_ff <= SQ_W'(p3_sq_ff[3]) + SQ_W'(p3_sq_ff[4]);
      p4_m_ff  <= p3_m_ff;
      p4_sb_ff <= p3_sb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
      end else begin
         p0_v_ff <= accept;
         p1_v_ff <= p0_v_ff;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
      end
   end

   // ---------------- square root chains ----------------
   logic [SQ_W-1:0]       sqz_rem  [ROOT_W+1];
   logic [ROOT_W-1:0]     sqz_root [ROOT_W+1];
   logic [SQ_W-1:0]       sqx_rem  [ROOT_W+1];
   logic [ROOT_W-1:0]     sqx_root [ROOT_W+1];
   logic                  sq_v_ff  [ROOT_W];
   logic [SB_W-1:0]       sq_sb_ff [ROOT_W];
   logic [NORM_BITS-1:0]  sq_m_ff  [ROOT_W][LANES];

   assign sqz_rem[0]  = p4_sz_ff;
   assign sqz_root[0] = '0;
   assign sqx_rem[0]  = p4_sx_ff;
   assign sqx_root[0] = '0;

   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      pfm_sqrt_cell #(.BIT(ROOT_W - 1 - j)) u_cell_z (
         .clock   (clock),
         .rem_in  (sqz_rem[j]),
         .root_in (sqz_root[j]),
         .rem_out (sqz_rem[j+1]),
         .root_out(sqz_root[j+1])
      );
      pfm_sqrt_cell #(.BIT(ROOT_W - 1 - j)) u_cell_x (
         .clock   (clock),
         .rem_in  (sqx_rem[j]),
         .root_in (sqx_root[j]),
         .rem_out (sqx_rem[j+1]),
         .root_out(sqx_root[j+1])
      );
   end

   // sideband rides alongside the root cells
   always_ff @(posedge clock) begin
      sq_sb_ff[0] <= p4_sb_ff;
      sq_m_ff[0]  <= p4_m_ff;
      for (int j = 1; j < ROOT_W; j++) begin
         sq_sb_ff[j] <= sq_sb_ff[j-1];
         sq_m_ff[j]  <= sq_m_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ROOT_W; j++) sq_v_ff[j] <= 1'b0;
      end else begin
         sq_v_ff[0] <= p4_v_ff;
         for (int j = 1; j < ROOT_W; j++) sq_v_ff[j] <= sq_v_ff[j-1];
      end
   end

   // ---------------- divider chains ----------------
   logic [DIV_W-1:0]  dv_rem [LANES][DIV_N+1];
   logic [DEN_W-1:0]  dv_den [LANES][DIV_N+1];
   logic [DIV_N-1:0]  dv_quo [LANES][DIV_N+1];
   logic              dv_v_ff  [DIV_N];
   logic [SB_W-1:0]   dv_sb_ff [DIV_N];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [ROOT_W-1:0] root;
      assign root = (l < 3) ? sqz_root[ROOT_W] : sqx_root[ROOT_W];
      // numerator 2*(m << F) + r over 2*r, rounding to nearest
      assign dv_rem[l][0] = (DIV_W'(sq_m_ff[ROOT_W-1][l]) << (F + 1)) + DIV_W'(root);
      assign dv_den[l][0] = {root, 1'b0};
      assign dv_quo[l][0] = '0;
      for (genvar j = 0; j < DIV_N; j++) begin : g_div
         pfm_div_cell #(.FRAC_BITS(F), .BIT(F - j)) u_cell (
            .clock  (clock),
            .rem_in (dv_rem[l][j]),
            .den_in (dv_den[l][j]),
            .quo_in (dv_quo[l][j]),
            .rem_out(dv_rem[l][j+1]),
            .den_out(dv_den[l][j+1]),
            .quo_out(dv_quo[l][j+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      dv_sb_ff[0] <= sq_sb_ff[ROOT_W-1];
      for (int j = 1; j < DIV_N; j++) dv_sb_ff[j] <= dv_sb_ff[j-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_N; j++) dv_v_ff[j] <= 1'b0;
      end else begin
         dv_v_ff[0] <= sq_v_ff[ROOT_W-1];
         for (int j = 1; j < DIV_N; j++) dv_v_ff[j] <= dv_v_ff[j-1];
      end
   end

   // ---------------- back stages ----------------
   logic [SB_W-1:0]           sb_out;
   logic signed [AXIS_W-1:0]  lane_val [LANES];
   logic                      a1_v_ff, a2_v_ff, a3_v_ff, a4_v_ff, a5_v_ff;
   logic signed [AXIS_W-1:0]  a1_z_ff [3], a1_x_ff [3];
   logic signed [W-1:0]       a1_o_ff [3], a2_o_ff [3], a3_o_ff [3];
   logic signed [AXIS_W-1:0]  a2_z_ff [3], a2_x_ff [3];
   logic signed [PW-1:0]      a2_p_ff [6];
   logic signed [AXIS_W-1:0]  a3_z_ff [3], a3_x_ff [3], a3_y_ff [3];
   logic signed [AXIS_W-1:0]  y_in [3];
   logic signed [AXIS_W-1:0]  a4_ax_ff [3][3];
   logic signed [DW-1:0]      a4_p_ff [3][3];
   logic signed [TW-1:0]      dot_sum [3], dot_rnd [3], dot_neg [3];
   logic signed [W-1:0]       shift_in [3];

   assign sb_out = dv_sb_ff[DIV_N-1];

   // signed axes with the fallbacks for a zero vector
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_val[l] = sb_out[SB_S + l] ? -$signed({1'b0, dv_quo[l][DIV_N]})
                                        : $signed({1'b0, dv_quo[l][DIV_N]});
      end
   end

   always_ff @(posedge clock) begin
      if (sb_out[SB_ZZ]) begin
         a1_z_ff[0] <= '0;
         a1_z_ff[1] <= '0;
         a1_z_ff[2] <= AXIS_ONE;
      end else begin
         a1_z_ff[0] <= lane_val[0];
         a1_z_ff[1] <= lane_val[1];
         a1_z_ff[2] <= lane_val[2];
      end
      if (sb_out[SB_ZX]) begin
         a1_x_ff[0] <= AXIS_ONE;
         a1_x_ff[1] <= '0;
      end else begin
         a1_x_ff[0] <= lane_val[3];
         a1_x_ff[1] <= lane_val[4];
      end
      a1_x_ff[2] <= '0;
      a1_o_ff[0] <= sb_out[SB_O +: W];
      a1_o_ff[1] <= sb_out[SB_O + W +: W];
      a1_o_ff[2] <= sb_out[SB_O + 2 * W +: W];
   end

   // cross product terms of y = z cross x
   always_ff @(posedge clock) begin
      a2_p_ff[0] <= a1_z_ff[1] * a1_x_ff[2];
      a2_p_ff[1] <= a1_z_ff[2] * a1_x_ff[1];
      a2_p_ff[2] <= a1_z_ff[2] * a1_x_ff[0];
      a2_p_ff[3] <= a1_z_ff[0] * a1_x_ff[2];
      a2_p_ff[4] <= a1_z_ff[0] * a1_x_ff[1];
      a2_p_ff[5] <= a1_z_ff[1] * a1_x_ff[0];
      a2_z_ff    <= a1_z_ff;
      a2_x_ff    <= a1_x_ff;
      a2_o_ff    <= a1_o_ff;
   end

   // round half away from zero and clamp to one
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [PW:0] diff;
         logic [PW:0]        mag, qm;
         diff = (PW + 1)'(a2_p_ff[2*i]) - (PW + 1)'(a2_p_ff[2*i+1]);
         mag  = diff[PW] ? -diff : diff;
         qm   = (mag + Y_HALF) >> F;
         if (qm > (PW + 1)'(AXIS_ONE)) qm = (PW + 1)'(AXIS_ONE);
         y_in[i] = diff[PW] ? -$signed(qm[AXIS_W-1:0]) : $signed(qm[AXIS_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      a3_y_ff <= y_in;
      a3_z_ff <= a2_z_ff;
      a3_x_ff <= a2_x_ff;
      a3_o_ff <= a2_o_ff;
   end

   // dot product terms of each axis with the origin
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a4_p_ff[0][i] <= a3_x_ff[i] * a3_o_ff[i];
         a4_p_ff[1][i] <= a3_y_ff[i] * a3_o_ff[i];
         a4_p_ff[2][i] <= a3_z_ff[i] * a3_o_ff[i];
      end
      a4_ax_ff[0] <= a3_x_ff;
      a4_ax_ff[1] <= a3_y_ff;
      a4_ax_ff[2] <= a3_z_ff;
   end

   // round half up, negate and saturate
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dot_sum[a] = TW'(a4_p_ff[a][0]) + TW'(a4_p_ff[a][1]) + TW'(a4_p_ff[a][2]);
         dot_rnd[a] = (dot_sum[a] + DOT_HALF) >>> F;
         dot_neg[a] = -dot_rnd[a];
         if (dot_neg[a] > SAT_HI)      shift_in[a] = SAT_HI[W-1:0];
         else if (dot_neg[a] < SAT_LO) shift_in[a] = SAT_LO[W-1:0];
         else                          shift_in[a] = dot_neg[a][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_axis_x_0 <= a4_ax_ff[0][0];
      rsp_axis_x_1 <= a4_ax_ff[0][1];
      rsp_axis_x_2 <= a4_ax_ff[0][2];
      rsp_axis_y_0 <= a4_ax_ff[1][0];
      rsp_axis_y_1 <= a4_ax_ff[1][1];
      rsp_axis_y_2 <= a4_ax_ff[1][2];
      rsp_axis_z_0 <= a4_ax_ff[2][0];
      rsp_axis_z_1 <= a4_ax_ff[2][1];
      rsp_axis_z_2 <= a4_ax_ff[2][2];
      rsp_shift_x  <= shift_in[0];
      rsp_shift_y  <= shift_in[1];
      rsp_shift_z  <= shift_in[2];
   end

   // valid bits of the back stages
   always_ff @(posedge clock) begin
      if (reset) begin
         a1_v_ff <= 1'b0;
         a2_v_ff <= 1'b0;
         a3_v_ff <= 1'b0;
         a4_v_ff <= 1'b0;
         a5_v_ff <= 1'b0;
      end else begin
         a1_v_ff <= dv_v_ff[DIV_N-1];
         a2_v_ff <= a1_v_ff;
         a3_v_ff <= a2_v_ff;
         a4_v_ff <= a3_v_ff;
         a5_v_ff <= a4_v_ff;
      end
   end

   assign rsp_strobe = a5_v_ff;

   // every transfer in gives exactly one result a fixed time later
   a_lat_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_strobe) else $error("result missing after transfer");

   a_lat_bwd: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT)) else $error("result without transfer");

   // x axis lies in the horizontal plane
   a_x_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_axis_x_2 == '0) else $error("x axis has a z component");

   // the z component of the z axis stays within one
   a_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_axis_z_2 <= AXIS_ONE && rsp_axis_z_2 >= -AXIS_ONE))
      else $error("z axis out of range");

endmodule

FILE: hw/rtl/pfm_sqrt_cell.sv
// pfm_sqrt_cell: one cell of the integer square root chain, settles one root bit
// depends on pfm_pkg
module pfm_sqrt_cell #(
   parameter int BIT = 0
) (
   input  logic                      clock,
   input  logic [pfm_pkg::SQ_W-1:0]   rem_in,
   input  logic [pfm_pkg::ROOT_W-1:0] root_in,
   output logic [pfm_pkg::SQ_W-1:0]   rem_out,
   output logic [pfm_pkg::ROOT_W-1:0] root_out
);
   import pfm_pkg::*;

   localparam int TW = SQ_W + 2;

   logic [TW-1:0]     trial;
   logic              fits;
   logic [SQ_W-1:0]   rem_ff, rem_in_nxt;
   logic [ROOT_W-1:0] root_ff, root_in_nxt;

   // growth of the square when this root bit is set: 2*root*2^k + 4^k
   always_comb begin
      trial       = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
      fits        = TW'(rem_in) >= trial;
      rem_in_nxt  = fits ? (rem_in - trial[SQ_W-1:0]) : rem_in;
      root_in_nxt = fits ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
   end

   // hand the partial root and remainder to the next cell
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in_nxt;
      root_ff <= root_in_nxt;
   end

   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

FILE: hw/rtl/pfm_div_cell.sv
// pfm_div_cell: one cell of the restoring divider chain, settles one quotient bit
// depends on pfm_pkg
module pfm_div_cell #(
   parameter int FRAC_BITS = 14,
   parameter int BIT       = 0
) (
   input  logic                                        clock,
   input  logic [FRAC_BITS+pfm_pkg::NORM_BITS+1:0]     rem_in,
   input  logic [pfm_pkg::DEN_W-1:0]                   den_in,
   input  logic [FRAC_BITS:0]                          quo_in,
   output logic [FRAC_BITS+pfm_pkg::NORM_BITS+1:0]     rem_out,
   output logic [pfm_pkg::DEN_W-1:0]                   den_out,
   output logic [FRAC_BITS:0]                          quo_out
);
   import pfm_pkg::*;

   localparam int DIV_W = FRAC_BITS + NORM_BITS + 2;
   localparam int Q_W   = FRAC_BITS + 1;

   logic [DIV_W-1:0] trial;
   logic             fits;
   logic [DIV_W-1:0] rem_ff, rem_in_nxt;
   logic [DEN_W-1:0] den_ff;
   logic [Q_W-1:0]   quo_ff, quo_in_nxt;

   // compare and subtract the shifted divisor
   always_comb begin
      trial      = DIV_W'(den_in) << BIT;
      fits       = rem_in >= trial;
      rem_in_nxt = fits ? (rem_in - trial) : rem_in;
      quo_in_nxt = fits ? (quo_in | (Q_W'(1) << BIT)) : quo_in;
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in_nxt;
      den_ff <= den_in;
      quo_ff <= quo_in_nxt;
   end

   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;

endmodule

FILE: test/plane_frame_matrices_unit_tb.sv
// plane_frame_matrices_unit_tb: self-checking bench for the plane frame unit
// predicts each frame and inverse translation in bit-accurate fixed point
// depends on plane_frame_matrices_unit only
`timescale 1ns / 1ps

module plane_frame_matrices_unit_tb;

   localparam int CW = 32;
   localparam int AF = 14;
   localparam int AW = AF + 2;
   localparam longint AXIS_ONE = 64'sd1 << AF;
   localparam longint FRAC_MASK = (64'sd1 << AF) - 1;
   localparam int LATENCY = 56;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct {
      logic signed [AW-1:0] ax [9];
      logic signed [CW-1:0] sh [3];
   } frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CW-1:0] ox = '0, oy = '0, oz = '0, nx = '0, ny = '0, nz = '0;
   logic rsp_strobe;
   logic signed [AW-1:0] r_ax [9];
   logic signed [CW-1:0] r_sh [3];

   frame_type expected_frames [$];
   int mismatches = 0;
   longint cycles = 0;
   bit steady = 0;   // no idle gaps while set

   plane_frame_matrices_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_origin_x(ox), .req_origin_y(oy), .req_origin_z(oz),
      .req_normal_x(nx), .req_normal_y(ny), .req_normal_z(nz),
      .rsp_strobe(rsp_strobe),
      .rsp_axis_x_0(r_ax[0]), .rsp_axis_x_1(r_ax[1]), .rsp_axis_x_2(r_ax[2]),
      .rsp_axis_y_0(r_ax[3]), .rsp_axis_y_1(r_ax[4]), .rsp_axis_y_2(r_ax[5]),
      .rsp_axis_z_0(r_ax[6]), .rsp_axis_z_1(r_ax[7]), .rsp_axis_z_2(r_ax[8]),
      .rsp_shift_x(r_sh[0]), .rsp_shift_y(r_sh[1]), .rsp_shift_z(r_sh[2])
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // magnitude of a signed coordinate, most negative value included
   function automatic longint unsigned coord_mag(logic signed [CW-1:0] v);
      longint signed w;
      w = v;
      return w < 0 ? longint'(-w) : longint'(w);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // unit vector in Q2.14, returns 0 for a zero vector
   function automatic bit normalize(bit neg [3], longint unsigned mag [3],
                                    output longint signed u [3]);
      longint unsigned m [3];
      longint unsigned big, s, r, q;
      m = mag;
      big = m[0];
      if (m[1] > big) big = m[1];
      if (m[2] > big) big = m[2];
      if (big == 0) return 0;
      while (big >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         big >>= 1;
      end
      while (big < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         big <<= 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      r = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = (2 * (m[i] << AF) + r) / (2 * r);
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function automatic longint signed round_cross(longint signed v);
      longint signed q;
      longint unsigned half;
      half = 64'd1 << (AF - 1);
      if (v < 0) q = -longint'((longint'(-v) + half) >> AF);
      else q = longint'((longint'(v) + half) >> AF);
      if (q > AXIS_ONE) q = AXIS_ONE;
      if (q < -AXIS_ONE) q = -AXIS_ONE;
      return q;
   endfunction

   // -(axis . origin) rounded half up and saturated
   function automatic longint signed inverse_shift(longint signed a [3], bit oneg [3],
                                                   longint unsigned omag [3]);
      longint signed whole, frac, tw, tf, carry, rem, hi, lo;
      longint unsigned am;
      hi = (64'sd1 << (CW - 1)) - 1;
      lo = -hi - 1;
      whole = 0;
      frac = 0;
      for (int i = 0; i < 3; i++) begin
         am = a[i] < 0 ? longint'(-a[i]) : longint'(a[i]);
         tw = am * (omag[i] >> AF);
         tf = am * (omag[i] & FRAC_MASK);
         if ((a[i] < 0) != oneg[i]) begin
            tw = -tw;
            tf = -tf;
         end
         whole += tw;
         frac += tf;
      end
      if (frac >= 0) carry = frac >>> AF;
      else carry = -((-frac + FRAC_MASK) >>> AF);
      rem = frac - carry * AXIS_ONE;
      whole += carry;
      if (rem >= AXIS_ONE / 2) whole += 1;
      whole = -whole;
      if (whole > hi) whole = hi;
      if (whole < lo) whole = lo;
      return whole;
   endfunction

   function automatic frame_type plane_frame(logic signed [CW-1:0] o [3],
                                             logic signed [CW-1:0] n [3]);
      frame_type f;
      bit oneg [3], nneg [3], cneg [3];
      longint unsigned omag [3], nmag [3], cmag [3];
      longint signed zx [3], xx [3], yx [3];
      for (int i = 0; i < 3; i++) begin
         oneg[i] = o[i][CW-1];
         omag[i] = coord_mag(o[i]);
         nneg[i] = n[i][CW-1];
         nmag[i] = coord_mag(n[i]);
      end
      if (!normalize(nneg, nmag, zx)) begin
         zx[0] = 0; zx[1] = 0; zx[2] = AXIS_ONE;
      end
      cneg[0] = !nneg[1]; cmag[0] = nmag[1];
      cneg[1] = nneg[0];  cmag[1] = nmag[0];
      cneg[2] = 0;        cmag[2] = 0;
      if (!normalize(cneg, cmag, xx)) begin
         xx[0] = AXIS_ONE; xx[1] = 0; xx[2] = 0;
      end
      yx[0] = round_cross(zx[1] * xx[2] - zx[2] * xx[1]);
      yx[1] = round_cross(zx[2] * xx[0] - zx[0] * xx[2]);
      yx[2] = round_cross(zx[0] * xx[1] - zx[1] * xx[0]);
      for (int i = 0; i < 3; i++) begin
         f.ax[i] = xx[i][AW-1:0];
         f.ax[3 + i] = yx[i][AW-1:0];
         f.ax[6 + i] = zx[i][AW-1:0];
      end
      f.sh[0] = CW'(inverse_shift(xx, oneg, omag));
      f.sh[1] = CW'(inverse_shift(yx, oneg, omag));
      f.sh[2] = CW'(inverse_shift(zx, oneg, omag));
      return f;
   endfunction

   // check each result transfer against the oldest prediction
   always @(posedge clock) begin
      frame_type e;
      bit bad;
      if (!reset && rsp_strobe) begin
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            e = expected_frames.pop_front();
            bad = 0;
            for (int i = 0; i < 9; i++) if (r_ax[i] !== e.ax[i]) bad = 1;
            for (int i = 0; i < 3; i++) if (r_sh[i] !== e.sh[i]) bad = 1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  for (int i = 0; i < 9; i++)
                     $display("axis %0d exp %0d got %0d", i, e.ax[i], r_ax[i]);
                  for (int i = 0; i < 3; i++)
                     $display("shift %0d exp %0d got %0d", i, e.sh[i], r_sh[i]);
               end
            end
         end
      end
   end

   // send one plane, each cycle before it may idle at random
   task automatic send_plane(logic signed [CW-1:0] o0, o1, o2, n0, n1, n2);
      logic signed [CW-1:0] o [3], n [3];
      while (!steady && $urandom_range(99) < 38) begin
         start <= 1'b0;
         @(negedge clock);
      end
      ox <= o0; oy <= o1; oz <= o2; nx <= n0; ny <= n1; nz <= n2;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      o[0] = o0; o[1] = o1; o[2] = o2;
      n[0] = n0; n[1] = n1; n[2] = n2;
      expected_frames.push_back(plane_frame(o, n));
      @(negedge clock);
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(5))
         0: return {CW{1'b0}} | $urandom_range(3);
         1: return 32'h8000_0000 + $urandom_range(3);
         2: return 32'h7fff_ffff - $urandom_range(3);
         3: return $signed($urandom_range(2000)) - 1000;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_special_normals();
      send_plane(0, 0, 0, 0, 0, 0);
      send_plane(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0);
      send_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 32'h0001_0000);
      send_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 32'h8000_0000);
      send_plane(32'h0001_0000, 0, 0, 0, 0, 1);
      send_plane(32'h1234_5678, 32'h8765_4321, 1, 1, 0, 0);
      send_plane(32'hffff_ffff, 1, 32'hffff_ffff, 0, 32'h8000_0000, 0);
   endtask

   task automatic test_extreme_fields();
      send_plane(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_plane(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1);
      send_plane(32'h0000_8000, 32'hffff_8000, 32'h0000_7fff, 1, 32'hffff_ffff, 0);
      send_plane(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 3, 4, 0);
      send_plane(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 1, 1);
   endtask

   task automatic test_random_planes();
      for (int k = 0; k < 450; k++) begin
         steady = (k >= 150 && k < 250);
         send_plane(rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord());
      end
      steady = 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_special_normals();
      test_extreme_fields();
      test_random_planes();
      start <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/pfm_pkg.sv
hw/rtl/pfm_sqrt_cell.sv
hw/rtl/pfm_div_cell.sv
hw/rtl/plane_frame_matrices_unit.sv
test/plane_frame_matrices_unit_tb.sv
